>>> sv/plid_pkg.sv
// package with shared constants and types of the positional list block
`timescale 1ns / 1ps

package plid_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - CNT_W - IDX_W - VAL_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WR,
        ST_SHIFT_DN,
        ST_RESP,
        ST_RD_OUT
    } state_t;

endpackage

>>> sv/plid_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module plid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/positional_list_insert_delete_top.sv
// top level of the positional list with insert, delete and read-out
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries held in one RAM with a registered
// read. One request is worked at a time. A read-out gives one result per cycle while
// the sink is ready. Insert and delete move one entry per cycle through the RAM's
// single write port. A finished result waits in an output register, so the next
// request is taken while it is still unclaimed.
module positional_list_insert_delete_top #(
    parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // position [6:0], value [38:7], zero [39]
    input  logic [plid_pkg::S_DATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [plid_pkg::MODE_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value_res [31:0], index [37:32], entry_count [44:38], zero [47:45]
    output logic [plid_pkg::M_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [plid_pkg::STAT_W-1:0]   m_tuser,
    output logic                          m_tlast
);

    import plid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    at_reg, at_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             first_reg, first_next;
    logic [VAL_W-1:0] res_value_reg, res_value_next;
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    status_t          res_status_reg, res_status_next;

    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;
    logic             out_load;
    logic             out_free;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;

    mode_t            in_mode;
    logic [POS_W-1:0] in_position;
    logic [VAL_W-1:0] in_value;
    logic             s_accept;
    logic [POS_W-1:0] count_pos;
    logic [POS_W-1:0] ins_at;
    logic             ins_full;
    logic             ins_range;
    logic             list_empty;
    logic             del_range;
    logic [AW-1:0]    last_addr;

    assign in_mode     = mode_t'(s_tuser);
    assign in_position = s_tdata[POS_W-1:0];
    assign in_value    = s_tdata[POS_W+VAL_W-1:POS_W];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;

    assign count_pos  = POS_W'(count_reg);
    assign ins_at     = (in_mode == MODE_APPEND) ? count_pos : in_position;
    assign ins_full   = (count_reg >= CW'(DEPTH));
    assign ins_range  = (ins_at > count_pos);
    assign list_empty = (count_reg == '0);
    assign del_range  = (in_position >= count_pos);
    assign last_addr  = AW'(count_reg - 1'b1);

    assign out_free = !m_valid_reg || m_tready;

    plid_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_mode)
                        MODE_APPEND, MODE_INSERT:
                        begin
                            if (ins_full || ins_range)
                            begin
                                state_next = ST_RESP;
                            end
                            else if (ins_at == count_pos)
                            begin
                                state_next = ST_INS_WR;
                            end
                            else
                            begin
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        MODE_DELETE:
                        begin
                            state_next = (list_empty || del_range) ? ST_RESP : ST_SHIFT_DN;
                        end
                        MODE_READ:
                        begin
                            state_next = list_empty ? ST_RESP : ST_RD_OUT;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP:
            begin
                if (ptr_reg == at_reg)
                begin
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                state_next = ST_RESP;
            end
            ST_SHIFT_DN:
            begin
                if (ptr_reg == last_addr)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_OUT:
            begin
                if (out_free && (ptr_reg == last_addr))
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        ptr_next        = ptr_reg;
        at_next         = at_reg;
        val_next        = val_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data;
        out_load        = 1'b0;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    val_next       = in_value;
                    res_index_next = '0;
                    unique case (in_mode)
                        MODE_APPEND, MODE_INSERT:
                        begin
                            res_value_next = in_value;
                            if (ins_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (ins_range)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                res_status_next = STAT_OK;
                                res_index_next  = IDX_W'(ins_at);
                                at_next         = AW'(ins_at);
                                ptr_next        = last_addr;
                                rd_addr         = last_addr;
                            end
                        end
                        MODE_DELETE:
                        begin
                            res_value_next = '0;
                            if (list_empty)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else if (del_range)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                res_status_next = STAT_OK;
                                res_index_next  = IDX_W'(in_position);
                                ptr_next        = AW'(in_position);
                                rd_addr         = AW'(in_position);
                                first_next      = 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            res_value_next  = '0;
                            res_status_next = STAT_EMPTY;
                            ptr_next        = '0;
                            rd_addr         = '0;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg + 1'b1);
                if (ptr_reg != at_reg)
                begin
                    ptr_next = AW'(ptr_reg - 1'b1);
                    rd_addr  = AW'(ptr_reg - 1'b1);
                end
            end
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = at_reg;
                wr_data    = val_reg;
                count_next = CW'(count_reg + 1'b1);
            end
            ST_SHIFT_DN:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    res_value_next = rd_data;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(ptr_reg - 1'b1);
                end
                if (ptr_reg == last_addr)
                begin
                    count_next = CW'(count_reg - 1'b1);
                end
                else
                begin
                    ptr_next = AW'(ptr_reg + 1'b1);
                    rd_addr  = AW'(ptr_reg + 1'b1);
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = res_value_reg;
                    out_index_next  = res_index_reg;
                    out_count_next  = CNT_W'(count_reg);
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                end
            end
            ST_RD_OUT:
            begin
                // hold the read on the same entry while the output stalls
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = rd_data;
                    out_index_next  = IDX_W'(ptr_reg);
                    out_count_next  = CNT_W'(count_reg);
                    out_status_next = STAT_OK;
                    out_last_next   = (ptr_reg == last_addr);
                    if (ptr_reg != last_addr)
                    begin
                        ptr_next = AW'(ptr_reg + 1'b1);
                        rd_addr  = AW'(ptr_reg + 1'b1);
                    end
                end
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else
        begin
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        at_reg         <= at_next;
        val_reg        <= val_next;
        first_reg      <= first_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_count_reg, out_index_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == CW'($past(count_reg) + 1'b1))
        || (CW'(count_reg + 1'b1) == $past(count_reg)))
        else $error("entry count moved by more than one");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while stalled");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT_UP || state_reg == ST_SHIFT_DN) && wr_en)
        |-> (wr_addr != rd_addr))
        else $error("shift reads and writes the same entry");
`endif

endmodule

>>> bench/tb.sv
// testbench for the positional list: directed table, then random requests checked by a predictor
`timescale 1ns / 1ps

module tb;

    import plid_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int CYC_LIMIT  = 1_000_000;
    localparam int END_WAIT   = 100;
    localparam int SINK_HOLD  = 300;
    localparam int N_RANDOM   = 310;

    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIXED  = 2;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        status_t          st;
        logic             last;
    } result_t;

    typedef struct packed {
        mode_t            op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             typed;
        result_t          want;
    } req_row_t;

    localparam result_t NO_RES = '{32'd0, 6'd0, 7'd0, STAT_OK, 1'b0};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                m_tlast;

    // list contents and size as the block should hold them
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_cnt;
    result_t          step_out [$];
    result_t          pending_res [$];

    int  errors;
    int  cyc;
    int  n_req;
    int  n_results;
    int  n_full;
    int  peak_cnt;
    int  n_rand;
    int  sink_hold;
    bit  gaps_on;

    logic [VAL_W-1:0] corner_vals [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

    req_row_t plan [21] = '{
        '{MODE_READ,   7'd0,   32'h0,         1'b1, '{32'h0,         6'd0, 7'd0, STAT_EMPTY, 1'b1}},
        '{MODE_DELETE, 7'd0,   32'h0,         1'b1, '{32'h0,         6'd0, 7'd0, STAT_EMPTY, 1'b1}},
        '{MODE_INSERT, 7'd1,   32'h1234_5678, 1'b1, '{32'h1234_5678, 6'd0, 7'd0, STAT_RANGE, 1'b1}},
        '{MODE_APPEND, 7'd127, 32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 6'd0, 7'd1, STAT_OK,    1'b1}},
        '{MODE_INSERT, 7'd0,   32'h8000_0000, 1'b1, '{32'h8000_0000, 6'd0, 7'd2, STAT_OK,    1'b1}},
        '{MODE_INSERT, 7'd2,   32'hffff_ffff, 1'b1, '{32'hffff_ffff, 6'd2, 7'd3, STAT_OK,    1'b1}},
        '{MODE_INSERT, 7'd127, 32'h55aa_55aa, 1'b1, '{32'h55aa_55aa, 6'd0, 7'd3, STAT_RANGE, 1'b1}},
        '{MODE_INSERT, 7'd4,   32'h0,         1'b1, '{32'h0,         6'd0, 7'd3, STAT_RANGE, 1'b1}},
        '{MODE_DELETE, 7'd3,   32'ha5a5_a5a5, 1'b1, '{32'h0,         6'd0, 7'd3, STAT_RANGE, 1'b1}},
        '{MODE_DELETE, 7'd127, 32'h0,         1'b1, '{32'h0,         6'd0, 7'd3, STAT_RANGE, 1'b1}},
        '{MODE_READ,   7'd64,  32'h0,         1'b0, NO_RES},
        '{MODE_INSERT, 7'd1,   32'h0000_0001, 1'b0, NO_RES},
        '{MODE_DELETE, 7'd0,   32'h0,         1'b0, NO_RES},
        '{MODE_DELETE, 7'd2,   32'h0,         1'b0, NO_RES},
        '{MODE_APPEND, 7'd0,   32'hdead_beef, 1'b0, NO_RES},
        '{MODE_READ,   7'd0,   32'h0,         1'b0, NO_RES},
        '{MODE_DELETE, 7'd1,   32'h0,         1'b0, NO_RES},
        '{MODE_DELETE, 7'd0,   32'h0,         1'b0, NO_RES},
        '{MODE_DELETE, 7'd0,   32'h0,         1'b0, NO_RES},
        '{MODE_READ,   7'd0,   32'h0,         1'b1, '{32'h0,         6'd0, 7'd0, STAT_EMPTY, 1'b1}},
        '{MODE_APPEND, 7'd3,   32'h0,         1'b1, '{32'h0,         6'd0, 7'd1, STAT_OK,    1'b1}}
    };

    positional_list_insert_delete_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic result_t make_res(logic [VAL_W-1:0] v, int idx, status_t st, logic lst);
        return '{v, IDX_W'(idx), CNT_W'(list_cnt), st, lst};
    endfunction

    // updates the list for one request and leaves its results in step_out
    function automatic void list_apply(mode_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        int               at;
        logic [VAL_W-1:0] gone;
        step_out.delete();
        case (op)
            MODE_APPEND, MODE_INSERT:
            begin
                at = (op == MODE_APPEND) ? list_cnt : int'(pos);
                if (list_cnt >= LIST_DEPTH)
                    step_out.push_back(make_res(val, 0, STAT_FULL, 1'b1));
                else if (at > list_cnt)
                    step_out.push_back(make_res(val, 0, STAT_RANGE, 1'b1));
                else
                begin
                    for (int i = list_cnt; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_cnt++;
                    step_out.push_back(make_res(val, at, STAT_OK, 1'b1));
                end
            end
            MODE_DELETE:
            begin
                if (list_cnt == 0)
                    step_out.push_back(make_res('0, 0, STAT_EMPTY, 1'b1));
                else if (int'(pos) >= list_cnt)
                    step_out.push_back(make_res('0, 0, STAT_RANGE, 1'b1));
                else
                begin
                    gone = list_mem[pos];
                    for (int i = int'(pos); i + 1 < list_cnt; i++)
                        list_mem[i] = list_mem[i+1];
                    list_cnt--;
                    step_out.push_back(make_res(gone, int'(pos), STAT_OK, 1'b1));
                end
            end
            default:
            begin
                if (list_cnt == 0)
                    step_out.push_back(make_res('0, 0, STAT_EMPTY, 1'b1));
                else
                    for (int i = 0; i < list_cnt; i++)
                        step_out.push_back(make_res(list_mem[i], i, STAT_OK, i + 1 == list_cnt));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("%0t ns  mismatch %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_req(mode_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                            logic typed, result_t want);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        list_apply(op, pos, val);
        if (typed)
            pending_res.push_back(want);
        else
            foreach (step_out[i])
                pending_res.push_back(step_out[i]);
        n_req++;
        if (list_cnt > peak_cnt)
            peak_cnt = list_cnt;
        if (step_out[0].st == STAT_FULL)
            n_full++;
    endtask

    task automatic send_random(int bias);
        int               roll;
        mode_t            op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        roll = $urandom_range(0, 99);
        case (bias)
            BIAS_GROW:
                op = roll < 45 ? MODE_APPEND : roll < 85 ? MODE_INSERT :
                     roll < 93 ? MODE_DELETE : MODE_READ;
            BIAS_SHRINK:
                op = roll < 10 ? MODE_APPEND : roll < 20 ? MODE_INSERT :
                     roll < 88 ? MODE_DELETE : MODE_READ;
            default:
                op = roll < 25 ? MODE_APPEND : roll < 50 ? MODE_INSERT :
                     roll < 85 ? MODE_DELETE : MODE_READ;
        endcase
        if ($urandom_range(0, 4) == 0)
            pos = POS_W'($urandom_range(0, 127));
        else if (op == MODE_DELETE)
            pos = (list_cnt == 0) ? '0 : POS_W'($urandom_range(0, list_cnt - 1));
        else
            pos = POS_W'($urandom_range(0, list_cnt));
        val = ($urandom_range(0, 9) == 0) ? corner_vals[$urandom_range(0, 3)] : $urandom;
        send_req(op, pos, val, 1'b0, NO_RES);
        n_rand++;
    endtask

    task automatic wait_drained();
        while (pending_res.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin : chk
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[VAL_W-1:0], m_tdata[VAL_W +: IDX_W],
                    m_tdata[VAL_W+IDX_W +: CNT_W], status_t'(m_tuser), m_tlast};
            n_results++;
            if (pending_res.size() == 0)
                report_mismatch("result with none expected", got.val, '0);
            else
            begin
                want = pending_res.pop_front();
                if (got.val !== want.val)
                    report_mismatch("value_res", got.val, want.val);
                if (got.idx !== want.idx)
                    report_mismatch("index", VAL_W'(got.idx), VAL_W'(want.idx));
                if (got.cnt !== want.cnt)
                    report_mismatch("entry_count", VAL_W'(got.cnt), VAL_W'(want.cnt));
                if (got.st !== want.st)
                    report_mismatch("status", VAL_W'(got.st), VAL_W'(want.st));
                if (got.last !== want.last)
                    report_mismatch("last", VAL_W'(got.last), VAL_W'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, pending_res.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink: per-result gaps plus an occasional long hold
    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            n = (m_tvalid && m_tready && gaps_on) ? $urandom_range(0, 4) : 0;
            n += sink_hold;
            sink_hold = 0;
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int extra;
        int phase_items;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_APPEND;
        list_cnt = 0;
        gaps_on  = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_req(plan[i].op, plan[i].pos, plan[i].val, plan[i].typed, plan[i].want);
        s_tvalid <= 1'b0;
        wait_drained();

        // fill up to full and keep pushing; sink holds off early on
        extra = 0;
        phase_items = 0;
        while (extra < 10 && phase_items < 170)
        begin
            if (list_cnt == LIST_DEPTH)
                extra++;
            if (phase_items == 15)
                sink_hold = SINK_HOLD;
            send_random(BIAS_GROW);
            phase_items++;
        end

        // drain down to empty with no idle cycles on either side
        gaps_on = 1'b0;
        extra = 0;
        phase_items = 0;
        while (extra < 6 && phase_items < 170)
        begin
            if (list_cnt == 0)
                extra++;
            send_random(BIAS_SHRINK);
            phase_items++;
        end
        s_tvalid <= 1'b0;
        wait_drained();

        gaps_on = 1'b1;
        while (n_rand < N_RANDOM)
            send_random(BIAS_MIXED);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (END_WAIT) @(posedge clk);

        $display("run covered %0d requests (%0d directed), %0d results checked",
                 n_req, $size(plan), n_results);
        $display("list peaked at %0d entries, %0d requests rejected as full", peak_cnt, n_full);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
